// ===== hw/rtl/cset_pkg.sv =====
// Shared types, constants and helpers of the charge session energy tracker.
`timescale 1ns / 1ps

package cset_pkg;

   // Width of the running energy sum; it wraps at this many bits.
   localparam int ENERGY_WIDTH = 48;

   localparam int CURRENT_WIDTH   = 16;
   localparam int POWER_WIDTH     = 20;
   localparam int THRESHOLD_WIDTH = 15;
   localparam int TPS_WIDTH       = 8;
   localparam int SECONDS_WIDTH   = 32;
   localparam int OUT_ENERGY_WIDTH = 48;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 15;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_LIMIT     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICKS_PER_SECOND = 1'd1;

   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 15'd10;
   localparam logic [TPS_WIDTH-1:0]       TPS_RESET       = 8'd10;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_STARTING  = 2'd1,
      PH_CHARGING  = 2'd2,
      PH_COMPLETED = 2'd3
   } phase_type;

   typedef struct packed {
      logic [THRESHOLD_WIDTH-1:0] active_limit;
      logic [TPS_WIDTH-1:0]       ticks_per_second;
   } cfg_type;

   typedef struct packed {
      phase_type                   session_state;
      logic [SECONDS_WIDTH-1:0]    session_seconds;
      logic [OUT_ENERGY_WIDTH-1:0] session_energy;
      logic [SECONDS_WIDTH-1:0]    last_seconds;
      logic [OUT_ENERGY_WIDTH-1:0] last_energy;
      logic                        history_updated;
   } result_type;

   // Low output bits of an energy sum, zero filled when the sum is narrower.
   function automatic logic [OUT_ENERGY_WIDTH-1:0] energy_out(
      input logic [ENERGY_WIDTH-1:0] value
   );
      logic [63:0] wide;
      wide = 64'(value);
      return wide[OUT_ENERGY_WIDTH-1:0];
   endfunction

endpackage

// ===== hw/rtl/cset_csr.sv =====
// Configuration registers of the charge session energy tracker.
`timescale 1ns / 1ps

module cset_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [cset_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cset_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cset_pkg::cfg_type                   cfg
);

   logic [cset_pkg::THRESHOLD_WIDTH-1:0] threshold_ff, threshold_in;
   logic [cset_pkg::TPS_WIDTH-1:0]       tps_ff, tps_in;

   always_comb begin
      threshold_in = threshold_ff;
      tps_in       = tps_ff;
      if (csr_wen) begin
         case (csr_index)
            cset_pkg::CSR_ACTIVE_LIMIT: begin
               threshold_in = csr_wdata[cset_pkg::THRESHOLD_WIDTH-1:0];
            end
            cset_pkg::CSR_TICKS_PER_SECOND: begin
               tps_in = csr_wdata[cset_pkg::TPS_WIDTH-1:0];
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= cset_pkg::THRESHOLD_RESET;
         tps_ff       <= cset_pkg::TPS_RESET;
      end else begin
         threshold_ff <= threshold_in;
         tps_ff       <= tps_in;
      end
   end

   assign cfg.active_limit     = threshold_ff;
   assign cfg.ticks_per_second = tps_ff;

endmodule

// ===== hw/rtl/cset_core.sv =====
// Session state machine, second counter, trapezoid energy sum and history.
`timescale 1ns / 1ps

module cset_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic signed [cset_pkg::CURRENT_WIDTH-1:0] current_ma,
   input  logic signed [cset_pkg::POWER_WIDTH-1:0]   power_mw,
   input  cset_pkg::cfg_type                        cfg,
   output cset_pkg::result_type                     result
);

   cset_pkg::phase_type phase_ff, phase_in;
   logic [cset_pkg::TPS_WIDTH-1:0]        tick_ff, tick_in;
   logic [cset_pkg::SECONDS_WIDTH-1:0]    seconds_ff, seconds_in;
   logic [cset_pkg::ENERGY_WIDTH-1:0]     energy_ff, energy_in;
   logic signed [cset_pkg::POWER_WIDTH-1:0] prior_ff, prior_in;
   logic [cset_pkg::SECONDS_WIDTH-1:0]    saved_seconds_ff, saved_seconds_in;
   logic [cset_pkg::ENERGY_WIDTH-1:0]     saved_energy_ff, saved_energy_in;

   logic active;
   logic clear_session;
   logic integrate;
   logic latch_history;
   logic [cset_pkg::TPS_WIDTH-1:0] tick_inc;
   logic signed [cset_pkg::POWER_WIDTH:0] pair_sum;

   // A tick is active when the signed current lies strictly above the threshold.
   assign active = current_ma > $signed({1'b0, cfg.active_limit});

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            cset_pkg::PH_IDLE: begin
               if (active) phase_in = cset_pkg::PH_STARTING;
            end
            cset_pkg::PH_STARTING: begin
               phase_in = active ? cset_pkg::PH_CHARGING : cset_pkg::PH_IDLE;
            end
            cset_pkg::PH_CHARGING: begin
               if (!active) phase_in = cset_pkg::PH_COMPLETED;
            end
            cset_pkg::PH_COMPLETED: begin
               phase_in = active ? cset_pkg::PH_CHARGING : cset_pkg::PH_IDLE;
            end
            default: begin
               phase_in = cset_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Actions taken by the present phase on this tick.
   always_comb begin
      clear_session = 1'b0;
      integrate     = 1'b0;
      latch_history = 1'b0;
      case (phase_ff)
         cset_pkg::PH_STARTING:  clear_session = active;
         cset_pkg::PH_CHARGING:  integrate     = 1'b1;
         cset_pkg::PH_COMPLETED: latch_history = !active;
         default:                clear_session = 1'b0;
      endcase
   end

   assign tick_inc = tick_ff + 1'b1;
   assign pair_sum = (cset_pkg::POWER_WIDTH + 1)'(prior_ff)
                   + (cset_pkg::POWER_WIDTH + 1)'(power_mw);

   always_comb begin
      tick_in          = tick_ff;
      seconds_in       = seconds_ff;
      energy_in        = energy_ff;
      prior_in         = prior_ff;
      saved_seconds_in = saved_seconds_ff;
      saved_energy_in  = saved_energy_ff;
      if (clear_session) begin
         tick_in    = '0;
         seconds_in = '0;
         energy_in  = '0;
         prior_in   = '0;
      end
      if (integrate) begin
         // A zero ticks-per-second setting makes every tick a full second.
         if (tick_inc >= cfg.ticks_per_second) begin
            tick_in    = '0;
            seconds_in = seconds_ff + 1'b1;
         end else begin
            tick_in = tick_inc;
         end
         energy_in = energy_ff + cset_pkg::ENERGY_WIDTH'(pair_sum);
         prior_in  = power_mw;
      end
      if (latch_history) begin
         saved_seconds_in = seconds_ff;
         saved_energy_in  = energy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= cset_pkg::PH_IDLE;
         tick_ff          <= '0;
         seconds_ff       <= '0;
         energy_ff        <= '0;
         prior_ff         <= '0;
         saved_seconds_ff <= '0;
         saved_energy_ff  <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         tick_ff          <= tick_in;
         seconds_ff       <= seconds_in;
         energy_ff        <= energy_in;
         prior_ff         <= prior_in;
         saved_seconds_ff <= saved_seconds_in;
         saved_energy_ff  <= saved_energy_in;
      end
   end

   assign result.session_state   = phase_in;
   assign result.session_seconds = seconds_in;
   assign result.session_energy  = cset_pkg::energy_out(energy_in);
   assign result.last_seconds    = saved_seconds_in;
   assign result.last_energy     = cset_pkg::energy_out(saved_energy_in);
   assign result.history_updated = latch_history;

endmodule

// ===== hw/rtl/charge_session_energy_tracker.sv =====
// Top level of the charge session energy tracker: input word register, core, result register.
`timescale 1ns / 1ps

//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+----------------------------------------
//  req      | in        | req_valid/stall  | current_ma, power_mw
//  rsp      | out       | rsp_valid/stall  | state, seconds, energy, history, update
//  csr      | in        | csr_wen          | csr_index, csr_wdata
//
// One word is accepted per clock cycle while req_stall is low. It waits in the input
// register until the result register can take a word, then passes through the session
// logic into the result register, which raises rsp_valid.
// Reset clears the session state, the history and both valid flags, and loads
// the threshold with 10 mA and the ticks per second with 10.
// req_stall rises only while both registers are full and rsp_stall holds the result.

module charge_session_energy_tracker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [cset_pkg::CURRENT_WIDTH-1:0]  req_current_ma,
   input  logic signed [cset_pkg::POWER_WIDTH-1:0]    req_power_mw,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [1:0]                                rsp_session_state,
   output logic [cset_pkg::SECONDS_WIDTH-1:0]         rsp_session_seconds,
   output logic signed [cset_pkg::OUT_ENERGY_WIDTH-1:0] rsp_session_energy,
   output logic [cset_pkg::SECONDS_WIDTH-1:0]         rsp_last_seconds,
   output logic signed [cset_pkg::OUT_ENERGY_WIDTH-1:0] rsp_last_energy,
   output logic                                      rsp_history_updated,
   input  logic                                      csr_wen,
   input  logic [cset_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [cset_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   cset_pkg::cfg_type    cfg;
   cset_pkg::result_type core_result;
   cset_pkg::result_type rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [cset_pkg::CURRENT_WIDTH-1:0] current_ff;
   logic signed [cset_pkg::POWER_WIDTH-1:0]   power_ff;

   logic advance;   // the result register can take a word this cycle
   logic step;      // the held request word moves through the session logic
   logic req_take;  // a request word is accepted

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only on a transfer and need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         current_ff <= req_current_ma;
         power_ff   <= req_power_mw;
      end
      if (step) begin
         rsp_ff <= core_result;
      end
   end

   cset_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cset_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .current_ma (current_ff),
      .power_mw   (power_ff),
      .cfg        (cfg),
      .result     (core_result)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_session_state   = rsp_ff.session_state;
   assign rsp_session_seconds = rsp_ff.session_seconds;
   assign rsp_session_energy  = $signed(rsp_ff.session_energy);
   assign rsp_last_seconds    = rsp_ff.last_seconds;
   assign rsp_last_energy     = $signed(rsp_ff.last_energy);
   assign rsp_history_updated = rsp_ff.history_updated;

endmodule

// ===== hw/rtl/cset_checker.sv =====
// Port-level assertions for the charge session energy tracker and their bind.
`timescale 1ns / 1ps

module cset_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input logic [1:0]                                rsp_session_state,
   input logic [cset_pkg::SECONDS_WIDTH-1:0]         rsp_session_seconds,
   input logic signed [cset_pkg::OUT_ENERGY_WIDTH-1:0] rsp_session_energy,
   input logic [cset_pkg::SECONDS_WIDTH-1:0]         rsp_last_seconds,
   input logic signed [cset_pkg::OUT_ENERGY_WIDTH-1:0] rsp_last_energy,
   input logic                                      rsp_history_updated
);

   // No result word is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // A word that latches history always ends the session in idle.
   a_history_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_history_updated)
         |-> rsp_session_state == cset_pkg::PH_IDLE)
      else $error("history latched outside idle");

   // The latched history equals the session totals of the same word.
   a_history_copy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_history_updated)
         |-> (rsp_last_seconds == rsp_session_seconds
              && rsp_last_energy == rsp_session_energy))
      else $error("history differs from session totals");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall)
         |=> (rsp_valid && $stable(rsp_session_seconds)
              && $stable(rsp_session_energy) && $stable(rsp_session_state)))
      else $error("stalled result word changed");

endmodule

bind charge_session_energy_tracker cset_checker u_cset_checker (.*);
